[rtl/lcdws_pkg.sv]
// Package for the character-LCD write sequencer.
// Holds the request, strobe and queue entry types, request kinds, wait codes and LCD constants.
// No dependencies.
`default_nettype none

package lcdws_pkg;

	// Default spacing between ordinary enable strobes, in microseconds
	localparam int ENABLE_PULSE_US_DEFAULT = 5;
	// Default depth of the byte queue between front and back
	localparam int BYTE_QUEUE_DEPTH_DEFAULT = 4;

	// Request kinds
	localparam logic [2:0] KIND_INIT    = 3'd0;
	localparam logic [2:0] KIND_CMD     = 3'd1;
	localparam logic [2:0] KIND_DATA    = 3'd2;
	localparam logic [2:0] KIND_CURSOR  = 3'd3;
	localparam logic [2:0] KIND_DATA_AT = 3'd4;

	// Wait codes carried with each byte to the back end
	typedef logic [1:0] wait_code_t;
	localparam wait_code_t WAIT_PULSE    = 2'd0;
	localparam wait_code_t WAIT_POWER_ON = 2'd1;
	localparam wait_code_t WAIT_SECOND   = 2'd2;
	localparam wait_code_t WAIT_THIRD    = 2'd3;

	localparam logic [14:0] WAIT_POWER_ON_US = 15'd20000;
	localparam logic [14:0] WAIT_SECOND_US   = 15'd5000;
	localparam logic [14:0] WAIT_THIRD_US    = 15'd150;

	// Command bytes
	localparam logic [7:0] CMD_FUNC_8BIT  = 8'h38;
	localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_HOME       = 8'h02;
	localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
	localparam logic [7:0] CMD_DDRAM_HOME = 8'h80;

	// Row base addresses
	localparam logic [7:0] ROW1_BASE = 8'h80;
	localparam logic [7:0] ROW2_BASE = 8'hC0;
	localparam logic [7:0] ROW3_BASE = 8'h94;
	localparam logic [7:0] ROW4_BASE = 8'hD4;

	// Last step index of the initialize sequence
	localparam logic [3:0] INIT_LAST_STEP = 4'd8;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] byte_value;
		logic [2:0] row;
		logic [5:0] column;
	} req_t;

	typedef struct packed {
		logic        reg_select;
		logic [7:0]  bus_value;
		logic [14:0] wait_before_us;
		logic        last;
	} rsp_t;

	// One byte write queued between front and back
	typedef struct packed {
		logic       rs;
		logic [7:0] value;
		wait_code_t wait_code;
		logic       last;
	} byte_op_t;

endpackage

`default_nettype wire

[rtl/lcdws_fifo.sv]
// Small register FIFO used as the byte queue between front and back.
// Generic in width and depth; no package dependency.
`default_nettype none

module lcdws_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic                  valid,
	output logic [WIDTH-1:0]      rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/lcdws_front.sv]
// Front end: accepts requests and breaks each into byte writes for the byte queue.
// Depends on lcdws_pkg.
`default_nettype none

module lcdws_front import lcdws_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire req_t req,
	input  wire logic bus_four_bit,
	input  wire logic q_full,
	output logic      q_push,
	output byte_op_t  q_data
);

	logic       busy_q;
	logic [2:0] kind_q;
	logic [7:0] byte_q;
	logic [7:0] addr_q;
	logic       row_ok_q;
	logic [3:0] step_q;

	logic       row_ok;
	logic [7:0] row_base;
	logic       has_byte;
	logic       fin;
	logic       advance;
	logic       done;
	logic       accept;

	// Byte of the initialize sequence at a given step
	function automatic logic [7:0] init_byte(input logic [3:0] step, input logic four);
		logic [7:0] b;
		unique case (step)
			4'd0, 4'd1, 4'd2: b = CMD_FUNC_8BIT;
			4'd3:             b = CMD_CLEAR;
			4'd4:             b = CMD_HOME;
			4'd5:             b = CMD_ENTRY_MODE;
			4'd6:             b = CMD_DISPLAY_ON;
			4'd7:             b = four ? CMD_FUNC_4BIT : CMD_FUNC_8BIT;
			default:          b = CMD_DDRAM_HOME;
		endcase
		return b;
	endfunction

	// Wait before the first strobe of an initialize step
	function automatic wait_code_t init_wait(input logic [3:0] step);
		wait_code_t w;
		unique case (step)
			4'd0:    w = WAIT_POWER_ON;
			4'd1:    w = WAIT_SECOND;
			4'd2:    w = WAIT_THIRD;
			default: w = WAIT_PULSE;
		endcase
		return w;
	endfunction

	// Classify row and pick its base address
	always_comb begin
		row_ok   = 1'b1;
		row_base = ROW1_BASE;
		unique case (req.row)
			3'd1:    row_base = ROW1_BASE;
			3'd2:    row_base = ROW2_BASE;
			3'd3:    row_base = ROW3_BASE;
			3'd4:    row_base = ROW4_BASE;
			default: row_ok   = 1'b0;
		endcase
	end

	// Decode the byte write for the current step
	always_comb begin
		has_byte         = 1'b1;
		fin              = 1'b1;
		q_data.rs        = 1'b0;
		q_data.value     = byte_q;
		q_data.wait_code = WAIT_PULSE;
		unique case (kind_q)
			KIND_INIT: begin
				q_data.value     = init_byte(step_q, bus_four_bit);
				q_data.wait_code = init_wait(step_q);
				fin              = (step_q == INIT_LAST_STEP);
			end
			KIND_CMD: begin
				q_data.rs = 1'b0;
			end
			KIND_DATA: begin
				q_data.rs = 1'b1;
			end
			KIND_CURSOR: begin
				has_byte     = row_ok_q;
				q_data.value = addr_q;
			end
			KIND_DATA_AT: begin
				if (step_q == 4'd0) begin
					q_data.value = addr_q;
					fin          = 1'b0;
				end else begin
					q_data.rs = 1'b1;
				end
			end
			default: begin
				has_byte = 1'b0;
			end
		endcase
		q_data.last = fin;
	end

	assign advance = busy_q && (!has_byte || !q_full);
	assign done    = advance && fin;
	assign full    = busy_q && !done;
	assign accept  = push && !full;
	assign q_push  = busy_q && has_byte && !q_full;

	// Hold the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= req.kind;
			byte_q   <= req.byte_value;
			addr_q   <= row_base + {2'b00, req.column} + 8'hFF;
			row_ok_q <= row_ok;
		end
	end

	// Track busy and step through the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			// skip the cursor write when the row is out of range
			step_q <= (req.kind == KIND_DATA_AT && !row_ok) ? 4'd1 : 4'd0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (advance) begin
			step_q <= step_q + 4'd1;
		end
	end

endmodule

`default_nettype wire

[rtl/lcdws_back.sv]
// Back end: expands queued byte writes into strobes, one per byte, or two nibbles per byte in four-bit mode.
// Depends on lcdws_pkg.
`default_nettype none

module lcdws_back import lcdws_pkg::*; #(
	parameter int ENABLE_PULSE_US = ENABLE_PULSE_US_DEFAULT
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     bus_four_bit,
	input  wire logic     q_valid,
	input  wire byte_op_t q_data,
	output logic          q_pop,
	output logic          empty,
	input  wire logic     pop,
	output rsp_t          rsp
);

	localparam logic [14:0] PULSE_US = 15'(ENABLE_PULSE_US);

	rsp_t       rsp_q;
	rsp_t       rsp_d;
	logic       out_valid_q;
	logic       half_q;
	logic       can_load;
	logic       load;
	logic [14:0] first_wait;

	// Expand the wait code
	always_comb begin
		unique case (q_data.wait_code)
			WAIT_POWER_ON: first_wait = WAIT_POWER_ON_US;
			WAIT_SECOND:   first_wait = WAIT_SECOND_US;
			WAIT_THIRD:    first_wait = WAIT_THIRD_US;
			default:       first_wait = PULSE_US;
		endcase
	end

	assign can_load = !out_valid_q || pop;
	assign load     = can_load && q_valid;

	// Build the next strobe
	always_comb begin
		rsp_d.reg_select = q_data.rs;
		if (bus_four_bit) begin
			if (!half_q) begin
				rsp_d.bus_value      = {4'h0, q_data.value[7:4]};
				rsp_d.wait_before_us = first_wait;
				rsp_d.last           = 1'b0;
			end else begin
				rsp_d.bus_value      = {4'h0, q_data.value[3:0]};
				rsp_d.wait_before_us = PULSE_US;
				rsp_d.last           = q_data.last;
			end
		end else begin
			rsp_d.bus_value      = q_data.value;
			rsp_d.wait_before_us = first_wait;
			rsp_d.last           = q_data.last;
		end
	end

	assign q_pop = load && (!bus_four_bit || half_q);
	assign empty = !out_valid_q;
	assign rsp   = rsp_q;

	// Hold the strobe until taken
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	// Track output beat and nibble phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				half_q      <= bus_four_bit && !half_q;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/char_lcd_write_sequencer_top.sv]
// Top level of the character-LCD write sequencer.
// Depends on lcdws_pkg, lcdws_front, lcdws_fifo and lcdws_back.
`default_nettype none

// Turns requests (initialize, command, data, set cursor, data at position)
// into enable-strobed LCD bus writes, one result beat per strobe, each
// carrying the wait before it and a last flag on the final strobe of the
// request. The front end splits a request into byte writes at one byte per
// cycle while the byte queue has room (initialize: nine bytes) into a short
// byte queue; the back end emits one strobe per cycle while the result side
// keeps taking them, one per byte in eight-bit mode and two (high nibble
// first) in four-bit mode. Requests that cause no strobe put nothing into
// the queue. bus_four_bit resets to 1 and is written through the cfg channel,
// which is always ready; write it only while idle.
module char_lcd_write_sequencer_top import lcdws_pkg::*; #(
	parameter int ENABLE_PULSE_US  = ENABLE_PULSE_US_DEFAULT,
	parameter int BYTE_QUEUE_DEPTH = BYTE_QUEUE_DEPTH_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire req_t req,
	output logic      empty,
	input  wire logic pop,
	output rsp_t      rsp,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic cfg_data
);

	logic     bus_four_bit_q;
	logic     q_push, q_full, q_pop, q_valid;
	byte_op_t q_wr_data, q_rd_data;

	assign cfg_ready = 1'b1;

	// Hold the bus mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_four_bit_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			bus_four_bit_q <= cfg_data;
		end
	end

	lcdws_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req          (req),
		.bus_four_bit (bus_four_bit_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wr_data)
	);

	lcdws_fifo #(
		.WIDTH ($bits(byte_op_t)),
		.DEPTH (BYTE_QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_pop),
		.valid   (q_valid),
		.rd_data (q_rd_data)
	);

	lcdws_back #(
		.ENABLE_PULSE_US (ENABLE_PULSE_US)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.bus_four_bit (bus_four_bit_q),
		.q_valid      (q_valid),
		.q_data       (q_rd_data),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.rsp          (rsp)
	);

endmodule

`default_nettype wire

[verif/tb_char_lcd_write_sequencer_top.sv]
// Testbench for char_lcd_write_sequencer_top: directed table, then random requests in both bus
// modes, every strobe beat checked in order against an in-bench predictor of the LCD writes.
// Depends on lcdws_pkg and the RTL of the sequencer.
`timescale 1ns / 1ps

module tb_char_lcd_write_sequencer_top;
	import lcdws_pkg::*;

	localparam logic [14:0] PULSE_US      = 15'(ENABLE_PULSE_US_DEFAULT);
	localparam int          QUIET_CYCLES  = 32;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          SEGMENTS      = 6;
	localparam int          SEGMENT_ITEMS = 45;
	localparam int          TIMEOUT_NS    = 8_000_000;
	localparam int          REPORT_LIMIT  = 10;

	// Kinds the block ignores
	localparam logic [2:0] KIND_RSVD5 = 3'd5;
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;

	typedef enum logic {STEP_REQ, STEP_MODE} step_kind_t;

	typedef struct packed {
		step_kind_t op;
		logic       mode;
		req_t       r;
		logic [1:0] n_typed;
		rsp_t       typed_a;
		rsp_t       typed_b;
	} plan_row_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic push      = 1'b0;
	logic pop       = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_data  = 1'b0;
	req_t req       = '0;
	logic full, empty, cfg_ready;
	rsp_t rsp;

	// Predictor state and expected strobes
	logic      bus_four_bit   = 1'b1;
	rsp_t      pending_strobes[$];
	int        strobe_errors  = 0;
	plan_row_t plan[$];

	// Pacing controls for the request and result sides
	logic calm           = 1'b0;
	logic hold_pop       = 1'b0;
	logic random_started = 1'b0;
	int   pop_wait       = 0;

	char_lcd_write_sequencer_top #(
		.ENABLE_PULSE_US (ENABLE_PULSE_US_DEFAULT)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic rsp_t lcd_strobe(logic rs, logic [7:0] v, logic [14:0] w, logic l);
		rsp_t s;
		s.reg_select     = rs;
		s.bus_value      = v;
		s.wait_before_us = w;
		s.last           = l;
		return s;
	endfunction

	// One byte write: one beat in eight-bit mode, two nibble beats in four-bit mode
	function automatic void queue_byte(logic rs, logic [7:0] v, logic [14:0] first_wait);
		if (bus_four_bit) begin
			pending_strobes.push_back(lcd_strobe(rs, {4'h0, v[7:4]}, first_wait, 1'b0));
			pending_strobes.push_back(lcd_strobe(rs, {4'h0, v[3:0]}, PULSE_US, 1'b0));
		end else begin
			pending_strobes.push_back(lcd_strobe(rs, v, first_wait, 1'b0));
		end
	endfunction

	// Expand one accepted request into its strobes
	function automatic void predict_strobes(req_t r);
		int         first;
		logic [7:0] base;
		logic       row_ok;
		first  = pending_strobes.size();
		row_ok = 1'b1;
		case (r.row)
			3'd1:    base = ROW1_BASE;
			3'd2:    base = ROW2_BASE;
			3'd3:    base = ROW3_BASE;
			3'd4:    base = ROW4_BASE;
			default: begin
				base   = 8'h00;
				row_ok = 1'b0;
			end
		endcase
		case (r.kind)
			KIND_INIT: begin
				queue_byte(1'b0, CMD_FUNC_8BIT, WAIT_POWER_ON_US);
				queue_byte(1'b0, CMD_FUNC_8BIT, WAIT_SECOND_US);
				queue_byte(1'b0, CMD_FUNC_8BIT, WAIT_THIRD_US);
				queue_byte(1'b0, CMD_CLEAR, PULSE_US);
				queue_byte(1'b0, CMD_HOME, PULSE_US);
				queue_byte(1'b0, CMD_ENTRY_MODE, PULSE_US);
				queue_byte(1'b0, CMD_DISPLAY_ON, PULSE_US);
				queue_byte(1'b0, bus_four_bit ? CMD_FUNC_4BIT : CMD_FUNC_8BIT, PULSE_US);
				queue_byte(1'b0, CMD_DDRAM_HOME, PULSE_US);
			end
			KIND_CMD:  queue_byte(1'b0, r.byte_value, PULSE_US);
			KIND_DATA: queue_byte(1'b1, r.byte_value, PULSE_US);
			KIND_CURSOR, KIND_DATA_AT: begin
				// address wraps to 8 bits; column 0 lands one below the row base
				if (row_ok)
					queue_byte(1'b0, base + {2'b00, r.column} - 8'd1, PULSE_US);
				if (r.kind == KIND_DATA_AT)
					queue_byte(1'b1, r.byte_value, PULSE_US);
			end
			default: ;
		endcase
		if (pending_strobes.size() > first)
			pending_strobes[pending_strobes.size() - 1].last = 1'b1;
	endfunction

	function automatic void check_strobe(rsp_t got);
		rsp_t want;
		if (pending_strobes.size() == 0) begin
			strobe_errors++;
			if (strobe_errors <= REPORT_LIMIT)
				$display("unexpected strobe: rs=%0d bus=%h wait=%0d last=%0d",
					got.reg_select, got.bus_value, got.wait_before_us, got.last);
		end else begin
			want = pending_strobes.pop_front();
			if (got.reg_select !== want.reg_select || got.bus_value !== want.bus_value ||
			    got.wait_before_us !== want.wait_before_us || got.last !== want.last) begin
				strobe_errors++;
				if (strobe_errors <= REPORT_LIMIT)
					$display({"strobe mismatch: expected rs=%0d bus=%h wait=%0d last=%0d,",
						" got rs=%0d bus=%h wait=%0d last=%0d"},
						want.reg_select, want.bus_value, want.wait_before_us, want.last,
						got.reg_select, got.bus_value, got.wait_before_us, got.last);
			end
		end
	endfunction

	// Mostly no gap, some short, a few long; none in calm stretches
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			r.kind = KIND_INIT;
		else if (pick < 28)
			r.kind = KIND_CMD;
		else if (pick < 52)
			r.kind = KIND_DATA;
		else if (pick < 67)
			r.kind = KIND_CURSOR;
		else if (pick < 94)
			r.kind = KIND_DATA_AT;
		else begin
			case ($urandom_range(0, 2))
				0:       r.kind = KIND_RSVD5;
				1:       r.kind = KIND_RSVD6;
				default: r.kind = KIND_RSVD7;
			endcase
		end
		r.byte_value = 8'($urandom);
		// mostly valid rows, the rest anywhere in the field
		r.row    = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
		r.column = 6'($urandom);
		return r;
	endfunction

	function automatic plan_row_t req_step(logic [2:0] k, logic [7:0] bv, logic [2:0] rw,
		logic [5:0] c);
		plan_row_t s;
		s              = '0;
		s.op           = STEP_REQ;
		s.r.kind       = k;
		s.r.byte_value = bv;
		s.r.row        = rw;
		s.r.column     = c;
		return s;
	endfunction

	function automatic plan_row_t typed_step(logic [2:0] k, logic [7:0] bv, logic [2:0] rw,
		logic [5:0] c, logic [1:0] n, rsp_t first_beat, rsp_t second_beat);
		plan_row_t s;
		s         = req_step(k, bv, rw, c);
		s.n_typed = n;
		s.typed_a = first_beat;
		s.typed_b = second_beat;
		return s;
	endfunction

	function automatic plan_row_t mode_step(logic m);
		plan_row_t s;
		s      = '0;
		s.op   = STEP_MODE;
		s.mode = m;
		return s;
	endfunction

	// Hold the request until the block takes it
	task automatic offer_request(input req_t r);
		push <= 1'b1;
		req  <= r;
		do @(posedge clk); while (full);
	endtask

	task automatic idle_sender();
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drain all strobes, then let trailing no-strobe requests clear the pipeline
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_strobes.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_bus_mode(input logic four_bit);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= four_bit;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		bus_four_bit = four_bit;
	endtask

	// Result side: check each popped beat, then pick the next pop
	always @(posedge clk) begin
		if (pop && !empty)
			check_strobe(rsp);
		if (!arst_n || hold_pop) begin
			pop <= 1'b0;
		end else if (pop_wait > 0) begin
			pop      <= 1'b0;
			pop_wait = pop_wait - 1;
		end else begin
			pop      <= 1'b1;
			pop_wait = pick_gap();
		end
	end

	// Stall the result side for a long stretch once random traffic runs
	initial begin : backpressure
		int held;
		wait (random_started);
		repeat ($urandom_range(20, 60)) @(posedge clk);
		hold_pop <= 1'b1;
		for (held = 0; held < HOLD_CYCLES; held++)
			@(posedge clk);
		hold_pop <= 1'b0;
	end

	initial begin : stimulus
		req_t r;
		int   counted;
		int   seg;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Four-bit mode out of reset
		plan.push_back(typed_step(KIND_CMD, 8'hFF, 3'd0, 6'd0, 2'd2,
			lcd_strobe(1'b0, 8'h0F, PULSE_US, 1'b0), lcd_strobe(1'b0, 8'h0F, PULSE_US, 1'b1)));
		plan.push_back(typed_step(KIND_DATA, 8'h00, 3'd7, 6'd63, 2'd2,
			lcd_strobe(1'b1, 8'h00, PULSE_US, 1'b0), lcd_strobe(1'b1, 8'h00, PULSE_US, 1'b1)));
		plan.push_back(typed_step(KIND_DATA, 8'hA5, 3'd1, 6'd1, 2'd2,
			lcd_strobe(1'b1, 8'h0A, PULSE_US, 1'b0), lcd_strobe(1'b1, 8'h05, PULSE_US, 1'b1)));
		plan.push_back(req_step(KIND_INIT, 8'h00, 3'd0, 6'd0));
		plan.push_back(typed_step(KIND_CURSOR, 8'h00, 3'd1, 6'd1, 2'd2,
			lcd_strobe(1'b0, 8'h08, PULSE_US, 1'b0), lcd_strobe(1'b0, 8'h00, PULSE_US, 1'b1)));
		plan.push_back(req_step(KIND_CURSOR, 8'hFF, 3'd4, 6'd63));
		plan.push_back(req_step(KIND_CURSOR, 8'h00, 3'd2, 6'd0));
		plan.push_back(req_step(KIND_CURSOR, 8'h00, 3'd0, 6'd5));
		plan.push_back(req_step(KIND_CURSOR, 8'h00, 3'd5, 6'd5));
		plan.push_back(req_step(KIND_DATA_AT, 8'h41, 3'd3, 6'd10));
		plan.push_back(typed_step(KIND_DATA_AT, 8'hFF, 3'd7, 6'd63, 2'd2,
			lcd_strobe(1'b1, 8'h0F, PULSE_US, 1'b0), lcd_strobe(1'b1, 8'h0F, PULSE_US, 1'b1)));
		plan.push_back(req_step(KIND_RSVD5, 8'hFF, 3'd7, 6'd63));
		plan.push_back(req_step(KIND_RSVD6, 8'h00, 3'd1, 6'd1));
		// Eight-bit mode
		plan.push_back(mode_step(1'b0));
		plan.push_back(typed_step(KIND_CMD, 8'h00, 3'd0, 6'd0, 2'd1,
			lcd_strobe(1'b0, 8'h00, PULSE_US, 1'b1), '0));
		plan.push_back(typed_step(KIND_DATA, 8'hFF, 3'd0, 6'd0, 2'd1,
			lcd_strobe(1'b1, 8'hFF, PULSE_US, 1'b1), '0));
		plan.push_back(req_step(KIND_INIT, 8'hFF, 3'd7, 6'd63));
		plan.push_back(typed_step(KIND_CURSOR, 8'h00, 3'd3, 6'd1, 2'd1,
			lcd_strobe(1'b0, ROW3_BASE, PULSE_US, 1'b1), '0));
		plan.push_back(req_step(KIND_DATA_AT, 8'h7E, 3'd4, 6'd0));
		plan.push_back(typed_step(KIND_DATA_AT, 8'h00, 3'd0, 6'd0, 2'd1,
			lcd_strobe(1'b1, 8'h00, PULSE_US, 1'b1), '0));
		plan.push_back(req_step(KIND_CURSOR, 8'h00, 3'd6, 6'd63));
		plan.push_back(req_step(KIND_RSVD7, 8'hFF, 3'd7, 6'd63));
		// Back to four-bit, init picks up the new mode byte
		plan.push_back(mode_step(1'b1));
		plan.push_back(req_step(KIND_INIT, 8'h00, 3'd0, 6'd0));

		// Walk the directed table
		foreach (plan[i]) begin
			if (plan[i].op == STEP_MODE) begin
				write_bus_mode(plan[i].mode);
			end else begin
				offer_request(plan[i].r);
				if (plan[i].n_typed == 2'd0) begin
					predict_strobes(plan[i].r);
				end else begin
					pending_strobes.push_back(plan[i].typed_a);
					if (plan[i].n_typed == 2'd2)
						pending_strobes.push_back(plan[i].typed_b);
				end
				idle_sender();
			end
		end

		// Random segments, alternating bus mode, one segment without idling
		random_started <= 1'b1;
		for (seg = 0; seg < SEGMENTS; seg++) begin
			write_bus_mode(seg[0]);
			calm    = (seg == 3);
			counted = 0;
			while (counted < SEGMENT_ITEMS) begin
				r = random_request();
				offer_request(r);
				predict_strobes(r);
				if (r.kind <= KIND_DATA_AT)
					counted++;
				idle_sender();
			end
		end
		calm = 1'b0;

		wait_idle();
		if (strobe_errors == 0 && pending_strobes.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Hard stop in case the block hangs
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule

[char_lcd_write_sequencer_top.f]
rtl/lcdws_pkg.sv
rtl/lcdws_fifo.sv
rtl/lcdws_front.sv
rtl/lcdws_back.sv
rtl/char_lcd_write_sequencer_top.sv
verif/tb_char_lcd_write_sequencer_top.sv
